// File: src/dual_pattern_response_matcher_core_defines.svh
// Assertion macros shared by the dual pattern response matcher RTL.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef DUAL_PATTERN_RESPONSE_MATCHER_CORE_DEFINES_SVH
`define DUAL_PATTERN_RESPONSE_MATCHER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define DPRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define DPRM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define DPRM_ASSERT(lbl, prop, msg)
`define DPRM_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// File: src/dprm_pkg.sv
// Types and codes shared by the dual pattern response matcher modules.
// No dependencies.
`default_nettype none

package dprm_pkg;

  // Input opcodes.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_BYTE  = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // Result outcomes.
  localparam logic [1:0] OUT_FIRST   = 2'd0;
  localparam logic [1:0] OUT_SECOND  = 2'd1;
  localparam logic [1:0] OUT_TIMEOUT = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        pattern_select;
    logic [4:0]  char_position;
    logic [7:0]  data_byte;
    logic [5:0]  first_length;
    logic [5:0]  second_length;
    logic [15:0] limit_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [15:0] elapsed_ms;
  } out_item_t;

  // Classified commands passed from the front end to the back end.
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_START,
    CMD_BYTE,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        sel;
    logic [4:0]  pos;
    logic [7:0]  data;
    logic [5:0]  len1;
    logic [5:0]  len2;
    logic [15:0] timeout;
  } cmd_t;

  // Per-beat controls for one pattern lane.
  typedef struct packed {
    logic load;
    logic start;
    logic step;
  } lane_ctl_t;

endpackage

`default_nettype wire

// File: src/dprm_queue.sv
// Two-entry queue used between the front and back ends and on the result side.
// Depends on the assertion macro header.
`default_nettype none
`include "dual_pattern_response_matcher_core_defines.svh"

module dprm_queue #(
  parameter int W = 1
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  output logic              full,
  input  wire logic [W-1:0] wdata,
  input  wire logic         pop,
  output logic              empty,
  output logic [W-1:0]      rdata
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   cnt_r;
  logic         do_push;
  logic         do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `DPRM_ASSERT_NEVER(a_queue_overfill, cnt_r > 2'd2, "queue holds more than two beats")

endmodule

`default_nettype wire

// File: src/dprm_front.sv
// Front end: decodes an input beat into a command for the back end.
// Depends on dprm_pkg.
`default_nettype none

module dprm_front #(
  parameter int MAX_PATTERN_LEN = 32
) (
  input  wire dprm_pkg::in_item_t item,
  output dprm_pkg::cmd_t          cmd
);

  import dprm_pkg::*;

  logic [5:0] len1_clamped;
  logic [5:0] len2_clamped;

  // Lengths above the store depth saturate; a first length of zero means one.
  always_comb begin
    len1_clamped = item.first_length;
    if (int'(item.first_length) > MAX_PATTERN_LEN) begin
      len1_clamped = 6'(MAX_PATTERN_LEN);
    end
    if (len1_clamped == 6'd0) begin
      len1_clamped = 6'd1;
    end
    len2_clamped = item.second_length;
    if (int'(item.second_length) > MAX_PATTERN_LEN) begin
      len2_clamped = 6'(MAX_PATTERN_LEN);
    end
  end

  always_comb begin
    cmd.sel     = item.pattern_select;
    cmd.pos     = item.char_position;
    cmd.data    = item.data_byte;
    cmd.len1    = len1_clamped;
    cmd.len2    = len2_clamped;
    cmd.timeout = item.limit_ms;
    unique case (item.opcode)
      OP_LOAD: begin
        cmd.kind = (int'(item.char_position) < MAX_PATTERN_LEN) ? CMD_LOAD : CMD_NOP;
      end
      OP_START: begin
        cmd.kind = CMD_START;
      end
      OP_BYTE: begin
        cmd.kind = CMD_BYTE;
      end
      OP_TICK: begin
        cmd.kind = CMD_TICK;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/dprm_lane.sv
// One pattern lane: pattern store, match position and prefetched characters.
// Depends on dprm_pkg.
`default_nettype none

module dprm_lane #(
  parameter int MAX_PATTERN_LEN = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dprm_pkg::lane_ctl_t ctl,
  input  wire logic [4:0]          wr_pos,
  input  wire logic [7:0]          data,
  input  wire logic [5:0]          len_in,
  output logic                     complete
);

  import dprm_pkg::*;

  localparam int AW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int PW = $clog2(MAX_PATTERN_LEN + 1);
  localparam int CW = ((PW > 6) ? PW : 6) + 1;

  logic [7:0]    mem [MAX_PATTERN_LEN];
  logic [PW-1:0] pos_r;
  logic [PW-1:0] pos_nxt;
  logic [7:0]    cur_r;
  logic [7:0]    cur_nxt;
  logic [7:0]    c0_r;
  logic [7:0]    c1_r;
  logic [7:0]    rd_r;
  logic          byp_r;
  logic          byp_nxt;
  logic [7:0]    byp_d_r;
  logic [5:0]    len_r;
  logic [7:0]    pf;
  logic          hit;
  logic [CW-1:0] ra;
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] wr_idx;

  // cur_r always holds the character at pos_r; rd_r (or the bypassed write)
  // holds the one after it, so a hit advances without a read in the path.
  assign pf       = byp_r ? byp_d_r : rd_r;
  assign hit      = (data == cur_r);
  assign complete = hit && ((CW'(pos_r) + CW'(1)) >= CW'(len_r));
  assign wr_idx   = AW'(wr_pos);

  always_comb begin
    pos_nxt = pos_r;
    cur_nxt = cur_r;
    if (ctl.start) begin
      pos_nxt = '0;
      cur_nxt = c0_r;
    end else if (ctl.step) begin
      if (hit) begin
        pos_nxt = pos_r + PW'(1);
        cur_nxt = pf;
      end else if (data == c0_r) begin
        pos_nxt = PW'(1);
        cur_nxt = c1_r;
      end else begin
        pos_nxt = '0;
        cur_nxt = c0_r;
      end
    end else if (ctl.load && (CW'(wr_pos) == CW'(pos_r))) begin
      cur_nxt = data;
    end
    ra      = CW'(pos_nxt) + CW'(1);
    rd_idx  = (int'(ra) < MAX_PATTERN_LEN) ? AW'(ra) : '0;
    byp_nxt = ctl.load && (CW'(wr_pos) == ra);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      byp_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      byp_r <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    byp_d_r <= data;
    if (ctl.start) begin
      len_r <= len_in;
    end
    if (ctl.load && (wr_pos == 5'd0)) begin
      c0_r <= data;
    end
    if (ctl.load && (wr_pos == 5'd1)) begin
      c1_r <= data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mem[wr_idx] <= data;
    end
    rd_r <= mem[rd_idx];
  end

endmodule

`default_nettype wire

// File: src/dprm_back.sv
// Back end: executes commands against both pattern lanes and the tick timer.
// Depends on dprm_pkg, dprm_lane and the assertion macro header.
`default_nettype none
`include "dual_pattern_response_matcher_core_defines.svh"

module dprm_back #(
  parameter int MAX_PATTERN_LEN = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire dprm_pkg::cmd_t cmd,
  input  wire logic           cmd_valid,
  output logic                cmd_pop,
  input  wire logic           res_full,
  output logic                res_push,
  output dprm_pkg::out_item_t res
);

  import dprm_pkg::*;

  logic        go;
  logic        byte_idle;
  logic        waiting_r;
  logic        waiting_nxt;
  logic [15:0] timeout_r;
  logic [15:0] timeout_nxt;
  logic [15:0] elapsed_r;
  logic [15:0] elapsed_nxt;
  logic [15:0] elapsed_inc;
  logic [5:0]  len2_r;
  logic [5:0]  len2_nxt;
  lane_ctl_t   ctl1;
  lane_ctl_t   ctl2;
  logic        done1;
  logic        done2;

  assign go        = cmd_valid && !res_full;
  assign cmd_pop   = go;
  assign byte_idle = go && (cmd.kind == CMD_BYTE) && !waiting_r;

  // The second lane only advances when the first did not complete on this byte.
  always_comb begin
    ctl1.load  = go && (cmd.kind == CMD_LOAD) && !cmd.sel;
    ctl1.start = go && (cmd.kind == CMD_START);
    ctl1.step  = go && (cmd.kind == CMD_BYTE) && waiting_r;
    ctl2.load  = go && (cmd.kind == CMD_LOAD) && cmd.sel;
    ctl2.start = ctl1.start;
    ctl2.step  = ctl1.step && (len2_r != 6'd0) && !done1;
  end

  dprm_lane #(.MAX_PATTERN_LEN(MAX_PATTERN_LEN)) u_lane1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl1),
    .wr_pos   (cmd.pos),
    .data     (cmd.data),
    .len_in   (cmd.len1),
    .complete (done1)
  );

  dprm_lane #(.MAX_PATTERN_LEN(MAX_PATTERN_LEN)) u_lane2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl2),
    .wr_pos   (cmd.pos),
    .data     (cmd.data),
    .len_in   (cmd.len2),
    .complete (done2)
  );

  assign elapsed_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;

  always_comb begin
    waiting_nxt    = waiting_r;
    timeout_nxt    = timeout_r;
    elapsed_nxt    = elapsed_r;
    len2_nxt       = len2_r;
    res_push       = 1'b0;
    res.outcome    = OUT_TIMEOUT;
    res.elapsed_ms = elapsed_r;
    if (go) begin
      case (cmd.kind)
        CMD_START: begin
          timeout_nxt = cmd.timeout;
          elapsed_nxt = 16'd0;
          len2_nxt    = cmd.len2;
          if (cmd.timeout == 16'd0) begin
            res_push       = 1'b1;
            res.outcome    = OUT_TIMEOUT;
            res.elapsed_ms = 16'd0;
            waiting_nxt    = 1'b0;
          end else begin
            waiting_nxt = 1'b1;
          end
        end
        CMD_BYTE: begin
          if (waiting_r && done1) begin
            res_push    = 1'b1;
            res.outcome = OUT_FIRST;
            waiting_nxt = 1'b0;
          end else if (ctl2.step && done2) begin
            res_push    = 1'b1;
            res.outcome = OUT_SECOND;
            waiting_nxt = 1'b0;
          end
        end
        CMD_TICK: begin
          if (waiting_r) begin
            elapsed_nxt = elapsed_inc;
            if (elapsed_inc >= timeout_r) begin
              res_push       = 1'b1;
              res.outcome    = OUT_TIMEOUT;
              res.elapsed_ms = elapsed_inc;
              waiting_nxt    = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r <= 1'b0;
      timeout_r <= 16'd0;
      elapsed_r <= 16'd0;
      len2_r    <= 6'd0;
    end else begin
      waiting_r <= waiting_nxt;
      timeout_r <= timeout_nxt;
      elapsed_r <= elapsed_nxt;
      len2_r    <= len2_nxt;
    end
  end

  `DPRM_ASSERT(a_push_has_room, res_push |-> !res_full, "result pushed into a full queue")
  `DPRM_ASSERT(a_result_ends_wait, res_push |=> !waiting_r, "wait still armed after result")
  `DPRM_ASSERT(a_idle_byte_silent, byte_idle |-> !res_push, "result from a byte while idle")

endmodule

`default_nettype wire

// File: src/dual_pattern_response_matcher_core.sv
// Top level of the dual pattern response matcher.
// Depends on dprm_pkg, dprm_front, dprm_queue and dprm_back.
// Throughput: one beat per cycle in each direction unless a full queue stalls it.
// A causing beat is registered in the command queue and its result in the result
// queue before the result is on the out_ ports. Synchronous active-low reset empties
// both queues and drops any wait; the pattern stores are not cleared.
`default_nettype none

module dual_pattern_response_matcher_core #(
  parameter int MAX_PATTERN_LEN = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire dprm_pkg::in_item_t in_item,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output dprm_pkg::out_item_t     out_item
);

  import dprm_pkg::*;

  // The front end is pure decode: it turns the incoming beat into a command,
  // resolving length saturation and dropping loads beyond the store depth.
  // Decoded commands wait in a two-entry queue so that the back end can be
  // stalled by a full result queue without the input side stopping at once.
  cmd_t      front_cmd;
  cmd_t      back_cmd;
  logic      cmd_empty;
  logic      cmd_pop;
  out_item_t back_res;
  logic      res_push;
  logic      res_full;

  dprm_front #(.MAX_PATTERN_LEN(MAX_PATTERN_LEN)) u_front (
    .item (in_item),
    .cmd  (front_cmd)
  );

  dprm_queue #(.W($bits(cmd_t))) u_cmd_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .full  (in_full),
    .wdata (front_cmd),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .rdata (back_cmd)
  );

  // The back end executes one command per cycle whenever the result queue has
  // room: loads, wait arming, byte matching on both lanes and tick counting.
  dprm_back #(.MAX_PATTERN_LEN(MAX_PATTERN_LEN)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (back_cmd),
    .cmd_valid (!cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  // Results are held here until the consumer pops them, so a slow consumer
  // only stalls the back end once two results are outstanding.
  dprm_queue #(.W($bits(out_item_t))) u_res_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .wdata (back_res),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (out_item)
  );

endmodule

`default_nettype wire

// File: tb/dprm_match_checker.sv
`timescale 1ns / 1ps
// Result checker for the dual pattern response matcher: predicts results from accepted
// input beats and compares them with the result beats. Depends on dprm_pkg.
module dprm_match_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_full,
  input  dprm_pkg::in_item_t  in_item,
  input  logic                out_empty,
  input  logic                out_pop,
  input  dprm_pkg::out_item_t out_item,
  output int                  mismatch_count,
  output int                  results_owed
);
  import dprm_pkg::*;

  localparam int MAX_LEN = 32;

  logic [7:0]  first_chars  [MAX_LEN];
  logic [7:0]  second_chars [MAX_LEN];
  logic [5:0]  first_pos, second_pos;
  logic [5:0]  first_len, second_len;
  logic [15:0] timeout_lim, ticks_seen;
  logic        armed;
  out_item_t   expected_results [$];
  int          fails = 0;

  function automatic logic [5:0] clamp_len(input logic [5:0] raw);
    return (raw > MAX_LEN) ? 6'(MAX_LEN) : raw;
  endfunction

  // Steps one pattern lane; returns 1 when the byte completes the pattern.
  function automatic logic lane_advance(input logic [7:0] at_pos, input logic [7:0] at_head,
                                        input logic [5:0] pos, input logic [5:0] len,
                                        input logic [7:0] rx, output logic [5:0] next_pos);
    if (rx == at_pos) begin
      next_pos = pos + 6'd1;
      return next_pos >= len;
    end
    next_pos = (rx == at_head) ? 6'd1 : 6'd0;
    return 1'b0;
  endfunction

  task automatic conclude(input logic [1:0] outcome);
    out_item_t r;
    armed = 1'b0;
    r.outcome = outcome;
    r.elapsed_ms = ticks_seen;
    expected_results.push_back(r);
  endtask

  task automatic predict_response(input in_item_t beat);
    logic [5:0] np;
    logic       done;
    logic [7:0] at_pos;
    case (beat.opcode)
      OP_LOAD: begin
        if (beat.pattern_select) second_chars[beat.char_position] = beat.data_byte;
        else first_chars[beat.char_position] = beat.data_byte;
      end
      OP_START: begin
        first_len = clamp_len(beat.first_length);
        if (first_len == 6'd0) first_len = 6'd1;
        second_len  = clamp_len(beat.second_length);
        timeout_lim = beat.limit_ms;
        first_pos   = 6'd0;
        second_pos  = 6'd0;
        ticks_seen  = 16'd0;
        armed       = 1'b1;
        if (timeout_lim == 16'd0) conclude(OUT_TIMEOUT);
      end
      OP_BYTE: begin
        if (armed) begin
          at_pos = (first_pos < MAX_LEN) ? first_chars[first_pos[4:0]] : 8'h00;
          done = lane_advance(at_pos, first_chars[0], first_pos, first_len, beat.data_byte, np);
          first_pos = np;
          if (done) begin
            conclude(OUT_FIRST);
          end else if (second_len != 6'd0) begin
            at_pos = (second_pos < MAX_LEN) ? second_chars[second_pos[4:0]] : 8'h00;
            done = lane_advance(at_pos, second_chars[0], second_pos, second_len,
                                beat.data_byte, np);
            second_pos = np;
            if (done) conclude(OUT_SECOND);
          end
        end
      end
      OP_TICK: begin
        if (armed) begin
          if (ticks_seen != 16'hFFFF) ticks_seen = ticks_seen + 16'd1;
          if (ticks_seen >= timeout_lim) conclude(OUT_TIMEOUT);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      $error("result beat with nothing expected: outcome %0d, elapsed_ms %0d",
             got.outcome, got.elapsed_ms);
      fails++;
    end else begin
      want = expected_results.pop_front();
      if (got.outcome !== want.outcome) begin
        $error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
        fails++;
      end
      if (got.elapsed_ms !== want.elapsed_ms) begin
        $error("elapsed_ms: expected %0d, got %0d", want.elapsed_ms, got.elapsed_ms);
        fails++;
      end
    end
  endtask

  // The pattern stores survive reset, as in the block itself.
  always @(posedge clk) begin
    if (!rst_n) begin
      first_pos   = 6'd0;
      second_pos  = 6'd0;
      first_len   = 6'd1;
      second_len  = 6'd0;
      timeout_lim = 16'd0;
      ticks_seen  = 16'd0;
      armed       = 1'b0;
      expected_results.delete();
    end else begin
      if (in_push && !in_full) predict_response(in_item);
      if (out_pop && !out_empty) check_result(out_item);
    end
    mismatch_count <= fails;
    results_owed   <= expected_results.size();
  end

endmodule

// File: tb/dual_pattern_response_matcher_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the dual pattern response matcher: clock, reset, stimulus and verdict.
// Depends on dprm_pkg, dual_pattern_response_matcher_core and dprm_match_checker.
module dual_pattern_response_matcher_core_tb;
  import dprm_pkg::*;

  localparam int MAX_LEN      = 32;
  localparam int TARGET_BEATS = 2000;
  localparam int DRAIN_CYCLES = 20;

  // How the result side paces its pops during one phase.
  typedef enum int {POP_EAGER, POP_COIN, POP_SLUGGISH} pop_mode_t;
  // What one armed wait is steered towards.
  typedef enum int {AIM_FIRST, AIM_SECOND, AIM_TIMEOUT, AIM_ABANDON} aim_t;

  logic      clk;
  logic      rst_n   = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_item = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_item;
  int        mismatches;
  int        owed;

  // The stimulus keeps its own view of what has been loaded into each pattern
  // store. It uses this to build matching byte runs, and to make sure that no
  // wait is ever armed over a character that has never been written.
  logic [7:0] pattern_text  [2][MAX_LEN];
  bit         pattern_known [2][MAX_LEN];

  int        burst_left     = 0;
  int        beats_sent     = 0;
  pop_mode_t pop_mode       = POP_EAGER;
  int        pop_phase_left = 0;

  dual_pattern_response_matcher_core #(
    .MAX_PATTERN_LEN(MAX_LEN)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  dprm_match_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_item       (in_item),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_item      (out_item),
    .mismatch_count(mismatches),
    .results_owed  (owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result side runs through phases of its own: popping at every edge,
  // popping on a coin toss, or popping only now and then. Phases last long
  // enough for the result queue to fill up while the sender keeps pushing.
  always @(posedge clk) begin
    if (pop_phase_left == 0) begin
      pop_mode       <= pop_mode_t'($urandom_range(0, 2));
      pop_phase_left <= $urandom_range(8, 160);
    end else begin
      pop_phase_left <= pop_phase_left - 1;
    end
    case (pop_mode)
      POP_EAGER: out_pop <= 1'b1;
      POP_COIN:  out_pop <= 1'($urandom_range(0, 1));
      default:   out_pop <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Every field gets random bits; the caller then sets those that the opcode
  // uses. This way the unused fields still see every bit toggle.
  function automatic in_item_t random_beat(input logic [1:0] op);
    in_item_t b;
    b.opcode         = op;
    b.pattern_select = 1'($urandom_range(0, 1));
    b.char_position  = 5'($urandom_range(0, 31));
    b.data_byte      = 8'($urandom_range(0, 255));
    b.first_length   = 6'($urandom_range(0, 63));
    b.second_length  = 6'($urandom_range(0, 63));
    b.limit_ms       = 16'($urandom_range(0, 65535));
    return b;
  endfunction

  // A small alphabet makes partial matches and fallbacks to the first
  // character common; the rest of the time any byte value is used.
  function automatic logic [7:0] pattern_char();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'h41 + 8'($urandom_range(0, 2));
  endfunction

  // Length actually held by the block for a given start field.
  function automatic int held_len(input logic [5:0] raw, input bit at_least_one);
    if (raw > MAX_LEN) return MAX_LEN;
    if (at_least_one && raw == 6'd0) return 1;
    return int'(raw);
  endfunction

  function automatic logic [5:0] random_len();
    case ($urandom_range(0, 15))
      0:       return 6'($urandom_range(33, 63));
      1:       return 6'($urandom_range(9, 32));
      default: return 6'($urandom_range(0, 8));
    endcase
  endfunction

  // Pushes one beat and returns at the edge that accepts it. The sender works
  // in bursts; between bursts in_push drops for a random gap, and now and then
  // there is no gap at all so that long back-to-back stretches occur.
  task automatic push_beat(input in_item_t beat);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 24);
    end
    if (beat.opcode == OP_LOAD) begin
      pattern_text[beat.pattern_select][beat.char_position]  = beat.data_byte;
      pattern_known[beat.pattern_select][beat.char_position] = 1'b1;
    end
    in_push <= 1'b1;
    in_item <= beat;
    @(posedge clk);
    while (in_full) @(posedge clk);
    burst_left--;
    beats_sent++;
  endtask

  task automatic load_char(input logic sel, input logic [4:0] pos, input logic [7:0] ch);
    in_item_t b;
    b = random_beat(OP_LOAD);
    b.pattern_select = sel;
    b.char_position  = pos;
    b.data_byte      = ch;
    push_beat(b);
  endtask

  task automatic send_byte(input logic [7:0] ch);
    in_item_t b;
    b = random_beat(OP_BYTE);
    b.data_byte = ch;
    push_beat(b);
  endtask

  task automatic send_tick();
    push_beat(random_beat(OP_TICK));
  endtask

  // Arms a wait. Any character that the new wait could read and that has not
  // been written yet is loaded first.
  task automatic start_wait(input logic [5:0] len1, input logic [5:0] len2,
                            input logic [15:0] limit);
    in_item_t b;
    int       need1, need2;
    need1 = held_len(len1, 1'b1);
    need2 = held_len(len2, 1'b0);
    for (int p = 0; p < need1; p++)
      if (!pattern_known[0][p]) load_char(1'b0, 5'(p), pattern_char());
    for (int p = 0; p < need2; p++)
      if (!pattern_known[1][p]) load_char(1'b1, 5'(p), pattern_char());
    b = random_beat(OP_START);
    b.first_length  = len1;
    b.second_length = len2;
    b.limit_ms      = limit;
    push_beat(b);
  endtask

  task automatic feed_prefix(input logic sel, input int count);
    for (int k = 0; k < count; k++) send_byte(pattern_text[sel][k]);
  endtask

  // One armed wait with random content. Most waits are steered to a match of
  // one pattern or to a timeout, after some false starts; a few are left to be
  // dropped by the next start.
  task automatic run_wait_episode();
    logic [5:0]  len1, len2;
    logic [15:0] limit;
    int          eff1, eff2, lane_len, fragments;
    aim_t        aim;
    logic        lane;
    len1 = random_len();
    len2 = ($urandom_range(0, 3) == 0) ? 6'd0 : random_len();
    case ($urandom_range(0, 9))
      0:       limit = 16'd0;
      1, 2, 3: limit = 16'($urandom_range(0, 65535));
      default: limit = 16'($urandom_range(1, 12));
    endcase
    start_wait(len1, len2, limit);
    eff1 = held_len(len1, 1'b1);
    eff2 = held_len(len2, 1'b0);

    // Now and then a pattern character is rewritten while the wait runs.
    if ($urandom_range(0, 9) == 0)
      load_char(1'($urandom_range(0, 1)), 5'($urandom_range(0, MAX_LEN - 1)), pattern_char());

    aim = aim_t'($urandom_range(0, 3));
    if (aim == AIM_SECOND && eff2 == 0) aim = AIM_FIRST;
    lane     = (aim == AIM_SECOND);
    lane_len = lane ? eff2 : eff1;

    // False starts: part of a pattern, then a byte that may break it, with the
    // odd tick in between.
    fragments = $urandom_range(0, 3);
    repeat (fragments) begin
      feed_prefix(lane, $urandom_range(0, lane_len - 1));
      if ($urandom_range(0, 1) == 0) send_byte(pattern_char());
      if ($urandom_range(0, 4) == 0) send_tick();
    end

    case (aim)
      AIM_FIRST:   feed_prefix(1'b0, eff1);
      AIM_SECOND:  feed_prefix(1'b1, eff2);
      AIM_TIMEOUT: begin
        repeat ((limit > 16) ? 16 : int'(limit)) begin
          if ($urandom_range(0, 2) == 0) send_byte(8'($urandom_range(0, 255)));
          send_tick();
        end
      end
      default: ;
    endcase
  endtask

  // Bytes, ticks and loads between waits; most arrive while idle.
  task automatic idle_noise();
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 2))
        0:       send_byte(8'($urandom_range(0, 255)));
        1:       send_tick();
        default: load_char(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)), pattern_char());
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Bytes and ticks while idle must be ignored.
    send_byte(8'h41);
    send_tick();
    // Extreme characters and positions.
    load_char(1'b0, 5'd0, 8'h41);
    load_char(1'b0, 5'd1, 8'h42);
    load_char(1'b1, 5'd0, 8'h41);
    load_char(1'b1, 5'd31, 8'hFF);
    load_char(1'b0, 5'd31, 8'h00);
    // Both patterns complete on the same byte: the first one wins.
    start_wait(6'd1, 6'd1, 16'd5);
    send_byte(8'h41);
    // A zero timeout ends the wait at once.
    start_wait(6'd2, 6'd1, 16'd0);
    // Fallback to position one on a repeated first character, after a tick.
    start_wait(6'd2, 6'd0, 16'hFFFF);
    send_tick();
    send_byte(8'h41);
    send_byte(8'h41);
    send_byte(8'h42);
    // Second pattern matches alone.
    load_char(1'b1, 5'd0, 8'h43);
    start_wait(6'd2, 6'd1, 16'd100);
    send_byte(8'h43);
    // A first length of zero is taken as one; the wait runs out of time.
    start_wait(6'd0, 6'd0, 16'd2);
    send_tick();
    send_tick();
    // Over-long lengths saturate; one tick is enough to time out.
    start_wait(6'd63, 6'd40, 16'd1);
    send_tick();
    // A start while waiting drops the old wait; a load while waiting takes
    // effect at once.
    start_wait(6'd63, 6'd63, 16'd3);
    start_wait(6'd2, 6'd0, 16'd9);
    send_byte(8'h41);
    load_char(1'b0, 5'd1, 8'h43);
    send_byte(8'h43);

    // Random part.
    while (beats_sent < TARGET_BEATS) begin
      if ($urandom_range(0, 6) == 0) idle_noise();
      run_wait_episode();
    end
    in_push <= 1'b0;

    // Let the last predictions settle, wait for every owed result, then give
    // any stray result beat a chance to show up.
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
